[rtl/ppmcd_pkg.sv]
// Package for the PPM pulse capture decoder.
// Holds register reset values, register indexes and the result word layout.
// No dependencies.
package ppmcd_pkg;

    localparam int unsigned MAX_CHANNELS_DEFAULT = 8;

    localparam int unsigned WIDTH_W     = 16;
    localparam int unsigned OVF_W       = 6;
    localparam int unsigned CHCOUNT_W   = 4;
    localparam int unsigned CHINDEX_W   = 3;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned S_DATA_W    = 24;
    localparam int unsigned M_DATA_W    = 32;

    localparam logic [WIDTH_W-1:0] SYNC_THRESHOLD_RESET = 16'd3000;
    localparam logic [OVF_W-1:0]   TIMEOUT_OVF_RESET    = 6'h3F;
    localparam logic [WIDTH_W-1:0] WIDTH_TIMEOUT        = 16'hFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SYNC_THRESHOLD    = 1'b0,
        CFG_TIMEOUT_OVERFLOWS = 1'b1
    } cfg_index_t;

    // First member sits in the top bits of the packed word.
    typedef struct packed {
        logic                 in_frame;
        logic [CHCOUNT_W-1:0] frame_channels;
        logic                 frame_done;
        logic [CHINDEX_W-1:0] channel_index;
        logic                 channel_valid;
        logic [WIDTH_W-1:0]   pulse_width;
        logic                 pulse_done;
        logic                 await_falling;
        logic                 restart_timer;
    } result_t;

endpackage

[rtl/ppm_pulse_capture_decoder.sv]
// PPM pulse capture decoder top level.
// Measures pulse widths from timer capture events and frames them into channels.
// Depends on ppmcd_pkg.
//
// Usage:
//   s_* channel takes one timer event word per accepted beat: overflow flag,
//   edge flag and the captured counter value. m_* channel returns exactly one
//   result word for every event word, in order.
//   cfg_* channel writes sync_threshold (index 0) or timeout_overflows
//   (index 1); it is always ready and should be used while the block is idle.
// Output: the result of an event word is registered and is on m_* in the cycle after acceptance.
// Throughput: one event word per cycle while m_tready is high; the pulse and frame
//   state update in the accept cycle, so back-to-back words chain through that single stage.
// Backpressure: the result register holds while m_tready is low; s_tready
//   stays high as long as the held word is taken in the same cycle.
// Reset: rst_n clears pulse and frame tracking, empties the result register
//   and loads sync_threshold = 3000 and timeout_overflows = 63.
module ppm_pulse_capture_decoder #(
    parameter int unsigned MAX_CHANNELS = ppmcd_pkg::MAX_CHANNELS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] overflow_event, [1] edge_event, [17:2] capture_value, [23:18] unused
    input  logic [ppmcd_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] restart_timer, [1] await_falling, [2] pulse_done, [18:3] pulse_width,
    // [19] channel_valid, [22:20] channel_index, [23] frame_done,
    // [27:24] frame_channels, [28] in_frame, [31:29] zero
    output logic [ppmcd_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ppmcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ppmcd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ppmcd_pkg::*;

    localparam int unsigned LIMIT_INT = (MAX_CHANNELS > 15) ? 15 : MAX_CHANNELS;
    localparam logic [CHCOUNT_W-1:0] CH_LIMIT = CHCOUNT_W'(LIMIT_INT);

    logic [WIDTH_W-1:0]   sync_threshold_reg;
    logic [OVF_W-1:0]     timeout_ovf_reg;
    logic                 high_seen_reg,     high_seen_next;
    logic [OVF_W-1:0]     ovf_count_reg,     ovf_count_next;
    logic                 frame_active_reg,  frame_active_next;
    logic [CHCOUNT_W-1:0] ch_count_reg,      ch_count_next;
    logic                 out_valid_reg;
    result_t              result_reg,        result_next;

    logic                 ovf_in;
    logic                 edge_in;
    logic [WIDTH_W-1:0]   cap_in;
    logic                 accept;
    logic                 done;
    logic [WIDTH_W-1:0]   width;

    assign ovf_in   = s_tdata[0];
    assign edge_in  = s_tdata[1];
    assign cap_in   = s_tdata[WIDTH_W+1:2];

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(M_DATA_W - $bits(result_t))'(0), result_reg};

    always_comb
    begin
        high_seen_next    = high_seen_reg;
        ovf_count_next    = ovf_count_reg;
        frame_active_next = frame_active_reg;
        ch_count_next     = ch_count_reg;
        done              = 1'b0;
        width             = '0;
        result_next       = '0;

        // overflow first; it may time the pulse out
        if (ovf_in && high_seen_reg) begin
            if (ovf_count_reg >= timeout_ovf_reg) begin
                done  = 1'b1;
                width = WIDTH_TIMEOUT;
            end else begin
                ovf_count_next = ovf_count_reg + 1'b1;
            end
        end

        if (edge_in) begin
            if (high_seen_reg) begin
                done  = 1'b1;
                width = cap_in;
            end else begin
                ovf_count_next            = '0;
                high_seen_next            = 1'b1;
                result_next.restart_timer = 1'b1;
            end
        end

        if (done) begin
            high_seen_next = 1'b0;
            ovf_count_next = '0;
            if (width > sync_threshold_reg) begin
                if (frame_active_reg) begin
                    result_next.frame_done     = 1'b1;
                    result_next.frame_channels = ch_count_reg;
                    frame_active_next          = 1'b0;
                end else begin
                    frame_active_next = 1'b1;
                end
                ch_count_next = '0;
            end else if (frame_active_reg && (ch_count_reg < CH_LIMIT)) begin
                result_next.channel_valid = 1'b1;
                result_next.channel_index = ch_count_reg[CHINDEX_W-1:0];
                ch_count_next             = ch_count_reg + 1'b1;
            end
        end

        result_next.pulse_done    = done;
        result_next.pulse_width   = width;
        result_next.await_falling = high_seen_next;
        result_next.in_frame      = frame_active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sync_threshold_reg <= SYNC_THRESHOLD_RESET;
            timeout_ovf_reg    <= TIMEOUT_OVF_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SYNC_THRESHOLD:    sync_threshold_reg <= cfg_data;
                CFG_TIMEOUT_OVERFLOWS: timeout_ovf_reg    <= cfg_data[OVF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            high_seen_reg    <= 1'b0;
            ovf_count_reg    <= '0;
            frame_active_reg <= 1'b0;
            ch_count_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                high_seen_reg    <= high_seen_next;
                ovf_count_reg    <= ovf_count_next;
                frame_active_reg <= frame_active_next;
                ch_count_reg     <= ch_count_next;
                out_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    a_idle_no_overflows: assert property (@(posedge clk) disable iff (!rst_n)
        !high_seen_reg |-> ovf_count_reg == '0)
        else $error("overflow count nonzero while waiting for rising edge");

    a_channel_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && result_reg.channel_valid) |->
            (result_reg.pulse_done && result_reg.in_frame && !result_reg.frame_done))
        else $error("channel reported outside an open frame");

    a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && result_reg.frame_done) |->
            (result_reg.pulse_done && !result_reg.in_frame))
        else $error("frame closed without a completed pulse or frame still open");

    a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !result_reg.pulse_done) |->
            (result_reg.pulse_width == '0 && !result_reg.channel_valid
             && !result_reg.frame_done))
        else $error("pulse fields set without a completed pulse");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ch_count_reg <= CH_LIMIT)
        else $error("channel count beyond limit");

endmodule
